@@ src/plhl_pkg.sv @@
`timescale 1ns / 1ps

package plhl_pkg;

    // Field widths
    localparam int POS_W   = 32;   // signed Q23.8
    localparam int HGT_W   = 24;   // signed Q15.8
    localparam int IDXIN_W = 6;
    localparam int CFG_W   = 7;
    localparam int FRAC_W  = 16;   // interpolation fraction bits
    localparam int FCNT_W  = 4;    // divider step counter
    localparam int PROD_W  = HGT_W + 1 + FRAC_W + 1;

    // Input operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Table read address select
    localparam logic [1:0] RD_FIRST = 2'd0;
    localparam logic [1:0] RD_LAST  = 2'd1;
    localparam logic [1:0] RD_MID   = 2'd2;

    // Result source select
    localparam logic [1:0] SRC_RD     = 2'd0;
    localparam logic [1:0] SRC_HI     = 2'd1;
    localparam logic [1:0] SRC_INTERP = 2'd2;

    typedef struct packed {
        logic       capture;    // latch query position and clamped count
        logic       mem_we;     // write one table entry
        logic [1:0] rd_sel;
        logic       save_lo;    // take read entry as lower bracket
        logic       save_hi;    // take read entry as upper bracket
        logic       move_lo;    // lower index to midpoint
        logic       move_hi;    // upper index to midpoint
        logic       div_init;
        logic       div_step;
        logic       mul_load;
        logic       res_load;
        logic [1:0] res_src;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic rd_lt_p;    // read position below query position
        logic rd_gt_p;    // read position above query position
        logic span_gt1;   // bracket still wider than one step
        logic hit;        // upper bracket sits exactly on the query
        logic div_done;   // last quotient bit this cycle
        logic out_free;   // output register can take a beat
    } status_t;

endpackage

@@ src/plhl_datapath.sv @@
`timescale 1ns / 1ps

module plhl_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  plhl_pkg::cmd_t                         cmd,
    output plhl_pkg::status_t                      st,
    input  logic                                   cfg_we,
    input  logic [plhl_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic [plhl_pkg::IDXIN_W-1:0]           entry_index,
    input  logic signed [plhl_pkg::POS_W-1:0]      entry_position,
    input  logic signed [plhl_pkg::HGT_W-1:0]      entry_height,
    input  logic signed [plhl_pkg::POS_W-1:0]      query_position,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [plhl_pkg::HGT_W-1:0]      height
);
    import plhl_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int MEM_W = POS_W + HGT_W;

    logic [CFG_W-1:0]          point_count_reg;
    logic signed [POS_W-1:0]   p_reg;
    logic [IDX_W-1:0]          last_reg;
    logic [IDX_W-1:0]          lo_reg;
    logic [IDX_W-1:0]          hi_reg;
    logic signed [POS_W-1:0]   pos_lo_reg;
    logic signed [POS_W-1:0]   pos_hi_reg;
    logic signed [HGT_W-1:0]   h_lo_reg;
    logic signed [HGT_W-1:0]   h_hi_reg;
    logic [MEM_W-1:0]          rd_word_reg;
    logic [POS_W-1:0]          rem_reg;
    logic [POS_W-1:0]          den_reg;
    logic [FRAC_W-1:0]         quo_reg;
    logic [FCNT_W-1:0]         step_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [HGT_W-1:0]   res_reg;
    logic                      out_valid_reg;
    logic signed [HGT_W-1:0]   out_height_reg;

    logic [MEM_W-1:0]          mem_array [MAX_POINTS];

    logic [31:0]               pc_ext;
    logic [31:0]               n_eff;
    logic [IDX_W-1:0]          mid;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic                      wr_ok;
    logic signed [POS_W-1:0]   rd_pos;
    logic signed [HGT_W-1:0]   rd_h;
    logic signed [POS_W:0]     num_wide;
    logic signed [POS_W:0]     den_wide;
    logic [POS_W:0]            rem_sh;
    logic signed [HGT_W:0]     h_diff;
    logic signed [PROD_W-FRAC_W-1:0] prod_hi;
    logic signed [PROD_W-FRAC_W-1:0] interp_sum;
    logic signed [HGT_W-1:0]   res_mux;

    // Clamp the configured count into 1..MAX_POINTS
    always_comb
    begin
        pc_ext = 32'(point_count_reg);
        if (pc_ext == 32'd0)
        begin
            n_eff = 32'd1;
        end
        else if (pc_ext > 32'(MAX_POINTS))
        begin
            n_eff = 32'(MAX_POINTS);
        end
        else
        begin
            n_eff = pc_ext;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            point_count_reg <= cfg_wdata;
        end
    end

    // Table addressing
    assign mid     = IDX_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign wr_addr = IDX_W'(32'(entry_index));
    assign wr_ok   = 32'(entry_index) < 32'(MAX_POINTS);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = last_reg;
            RD_MID:   rd_addr = mid;
            default:  rd_addr = '0;
        endcase
    end

    // Breakpoint table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_we && wr_ok)
        begin
            mem_array[wr_addr] <= {entry_position, entry_height};
        end
        rd_word_reg <= mem_array[rd_addr];
    end

    assign rd_pos = $signed(rd_word_reg[MEM_W-1:HGT_W]);
    assign rd_h   = $signed(rd_word_reg[HGT_W-1:0]);

    // Query capture and bracket tracking
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            p_reg    <= query_position;
            last_reg <= IDX_W'(n_eff - 32'd1);
            lo_reg   <= '0;
            hi_reg   <= IDX_W'(n_eff - 32'd1);
        end
        if (cmd.move_lo)
        begin
            lo_reg <= mid;
        end
        if (cmd.move_hi)
        begin
            hi_reg <= mid;
        end
        if (cmd.save_lo)
        begin
            pos_lo_reg <= rd_pos;
            h_lo_reg   <= rd_h;
        end
        if (cmd.save_hi)
        begin
            pos_hi_reg <= rd_pos;
            h_hi_reg   <= rd_h;
        end
    end

    // Restoring divider: one quotient bit per cycle, numerator below divisor
    assign num_wide = {p_reg[POS_W-1], p_reg} - {pos_lo_reg[POS_W-1], pos_lo_reg};
    assign den_wide = {pos_hi_reg[POS_W-1], pos_hi_reg} - {pos_lo_reg[POS_W-1], pos_lo_reg};
    assign rem_sh   = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg  <= num_wide[POS_W-1:0];
            den_reg  <= den_wide[POS_W-1:0];
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + FCNT_W'(1);
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= POS_W'(rem_sh - {1'b0, den_reg});
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[POS_W-1:0];
                quo_reg <= {quo_reg[FRAC_W-2:0], 1'b0};
            end
        end
    end

    // Scale the height step by the fraction, then add with floor shift
    assign h_diff     = {h_hi_reg[HGT_W-1], h_hi_reg} - {h_lo_reg[HGT_W-1], h_lo_reg};
    assign prod_hi    = prod_reg[PROD_W-1:FRAC_W];
    assign interp_sum = prod_hi + (PROD_W-FRAC_W)'(h_lo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(h_diff * $signed({1'b0, quo_reg}));
        end
    end

    always_comb
    begin
        case (cmd.res_src)
            SRC_RD:     res_mux = rd_h;
            SRC_HI:     res_mux = h_hi_reg;
            SRC_INTERP: res_mux = interp_sum[HGT_W-1:0];
            default:    res_mux = rd_h;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg <= res_mux;
        end
        if (cmd.out_load)
        begin
            out_height_reg <= res_reg;
        end
    end

    // Output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign height    = out_height_reg;

    // Status back to the controller
    assign st.rd_lt_p  = rd_pos < p_reg;
    assign st.rd_gt_p  = rd_pos > p_reg;
    assign st.span_gt1 = (hi_reg - lo_reg) > IDX_W'(1);
    assign st.hit      = pos_hi_reg == p_reg;
    assign st.div_done = step_reg == FCNT_W'(FRAC_W - 1);
    assign st.out_free = !out_valid_reg || !out_stall;

    // The divider always starts on a strict bracket, so the quotient fits
    a_div_bracket: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> (pos_lo_reg < p_reg) && (p_reg < pos_hi_reg))
        else $error("divider started without a strict bracket");

    // Midpoint steps only happen while the bracket is wider than one slot
    a_mid_span: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move_lo || cmd.move_hi) |-> (lo_reg < hi_reg) && (mid > lo_reg) && (mid < hi_reg))
        else $error("binary search stepped on a collapsed bracket");

endmodule

@@ src/plhl_ctrl.sv @@
`timescale 1ns / 1ps

module plhl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  plhl_pkg::status_t st,
    output plhl_pkg::cmd_t    cmd
);
    import plhl_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIRST  = 4'd1;
    localparam logic [3:0] S_LAST   = 4'd2;
    localparam logic [3:0] S_ISSUE  = 4'd3;
    localparam logic [3:0] S_CMP    = 4'd4;
    localparam logic [3:0] S_EXACT  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_ADD    = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign in_stall = state_reg != S_IDLE;
    assign accept   = in_valid && !in_stall;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_FIRST;
        cmd.res_src = SRC_RD;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && op == OP_QUERY)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FIRST;
                end
                else if (accept)
                begin
                    cmd.mem_we = 1'b1;
                end
            end
            S_FIRST:
            begin
                cmd.rd_sel = RD_LAST;
                if (!st.rd_lt_p)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.save_lo = 1'b1;
                    state_next  = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!st.rd_gt_p)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.save_hi = 1'b1;
                    state_next  = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.rd_sel = RD_MID;
                state_next = st.span_gt1 ? S_CMP : S_EXACT;
            end
            S_CMP:
            begin
                cmd.rd_sel = RD_MID;
                if (st.rd_lt_p)
                begin
                    cmd.save_lo = 1'b1;
                    cmd.move_lo = 1'b1;
                end
                else
                begin
                    cmd.save_hi = 1'b1;
                    cmd.move_hi = 1'b1;
                end
                state_next = S_ISSUE;
            end
            S_EXACT:
            begin
                if (st.hit)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_src  = SRC_HI;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = SRC_INTERP;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Never overwrite a beat that is still waiting
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending output beat");

    // Last quotient bit hands over to the multiply
    a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && st.div_done |=> state_reg == S_MUL)
        else $error("divider did not hand over to multiply");

    // An accepted query starts at the first-entry check
    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_FIRST) && in_stall)
        else $error("accepted query did not start the lookup");

endmodule

@@ src/piecewise_linear_height_lookup_unit.sv @@
// Piecewise linear height lookup. Holds up to MAX_POINTS (position, height)
// breakpoints, positions signed Q23.8 and heights signed Q15.8, which the
// user must keep sorted by ascending position; the block itself does not
// enforce the order. An input beat with op = 0 writes one entry and gives
// no output; writes can follow each other every cycle while the block is
// idle. An input beat with op = 1 gives one height: clamped to the first or
// last height outside the table range, otherwise interpolated between the
// bracketing pair found by binary search, with a truncated 16-bit fraction
// and a floor on the scaled step. A query checks the first, then the last
// entry, either of which can clamp, then runs the binary search, checks for
// an exact breakpoint hit and otherwise divides, multiplies and adds; it
// raises out_valid once the output register is free, in the same cycle that
// in_stall falls. Each search step reads the single-port table, and the
// divider gives one quotient bit per cycle. The next item is taken while a
// finished height still waits in the output register. point_count resets
// to 1 and must only be written by the user while the block is idle (the
// block does not enforce it); entries must be written before a query reads them.
`timescale 1ns / 1ps

module piecewise_linear_height_lookup_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [plhl_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   op,
    input  logic [plhl_pkg::IDXIN_W-1:0]           entry_index,
    input  logic signed [plhl_pkg::POS_W-1:0]      entry_position,
    input  logic signed [plhl_pkg::HGT_W-1:0]      entry_height,
    input  logic signed [plhl_pkg::POS_W-1:0]      query_position,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [plhl_pkg::HGT_W-1:0]      height
);
    import plhl_pkg::*;

    cmd_t    cmd;
    status_t st;

    // Sequencer
    plhl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .st       (st),
        .cmd      (cmd)
    );

    // Table, search bracket, divider, multiplier and output register
    plhl_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .entry_index    (entry_index),
        .entry_position (entry_position),
        .entry_height   (entry_height),
        .query_position (query_position),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .height         (height)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import plhl_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS = 29;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint POS_MAX = 64'sd2147483647;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_stall;
    logic op;
    logic [IDXIN_W-1:0] entry_index;
    logic signed [POS_W-1:0] entry_position;
    logic signed [HGT_W-1:0] entry_height;
    logic signed [POS_W-1:0] query_position;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [HGT_W-1:0] height;

    // Shadow copy of the breakpoint table and the count register
    logic signed [POS_W-1:0] shadow_pos [TABLE_DEPTH];
    logic signed [HGT_W-1:0] shadow_hgt [TABLE_DEPTH];
    logic [CFG_W-1:0] shadow_count;

    logic signed [HGT_W-1:0] expected_heights [$];
    logic signed [HGT_W-1:0] head_height;
    bit steady_flow = 1'b0;
    int fail_count = 0;
    int query_count = 0;
    int write_count = 0;
    int checked_count = 0;
    int cycle_count = 0;

    piecewise_linear_height_lookup_unit #(
        .MAX_POINTS(TABLE_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .entry_index(entry_index),
        .entry_position(entry_position),
        .entry_height(entry_height),
        .query_position(query_position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .height(height)
    );

    always #5 clk = ~clk;

    // Clamp the count register the way the block reads it
    function automatic int unsigned active_points();
        int unsigned n;
        n = 32'(shadow_count);
        if (n < 1)
            n = 1;
        if (n > TABLE_DEPTH)
            n = TABLE_DEPTH;
        return n;
    endfunction

    // Height at a position: clamp at the ends, else binary search and interpolate
    function automatic logic signed [HGT_W-1:0] interpolate_height(
        input logic signed [POS_W-1:0] p
    );
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint span_num;
        longint span_den;
        longint frac;
        longint step;
        n = active_points();
        if (p <= shadow_pos[0])
            return shadow_hgt[0];
        if (p >= shadow_pos[n-1])
            return shadow_hgt[n-1];
        lo = 0;
        hi = n - 1;
        // keep pos[lo] < p <= pos[hi]
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (shadow_pos[mid] < p)
                lo = mid;
            else
                hi = mid;
        end
        if (shadow_pos[hi] == p)
            return shadow_hgt[hi];
        span_num = longint'(p) - longint'(shadow_pos[lo]);
        span_den = longint'(shadow_pos[hi]) - longint'(shadow_pos[lo]);
        frac = (span_num <<< 16) / span_den;
        if (frac > 65535)
            frac = 65535;
        step = (longint'(shadow_hgt[hi]) - longint'(shadow_hgt[lo])) * frac;
        // arithmetic shift floors toward minus infinity
        return HGT_W'(longint'(shadow_hgt[lo]) + (step >>> 16));
    endfunction

    function automatic logic signed [HGT_W-1:0] pick_height();
        case ($urandom_range(5))
            0: return 24'sh800000;
            1: return 24'sh7FFFFF;
            default: return HGT_W'($urandom);
        endcase
    endfunction

    // Bias query positions toward brackets, breakpoints and the rails
    function automatic logic signed [POS_W-1:0] pick_query_position();
        int unsigned n;
        int unsigned k;
        longint lo_pos;
        longint hi_pos;
        n = active_points();
        k = $urandom_range(n - 1);
        case ($urandom_range(9))
            0, 1: return POS_W'($urandom);
            2: return shadow_pos[k];
            3: return $urandom_range(1) ? shadow_pos[k] + 1 : shadow_pos[k] - 1;
            4: return $urandom_range(1) ? POS_W'(POS_MIN + $urandom_range(3))
                                        : POS_W'(POS_MAX - $urandom_range(3));
            default:
            begin
                if (n < 2)
                    return POS_W'($urandom);
                k = $urandom_range(n - 2);
                lo_pos = shadow_pos[k];
                hi_pos = shadow_pos[k+1];
                if (hi_pos < lo_pos)
                begin
                    lo_pos = shadow_pos[k+1];
                    hi_pos = shadow_pos[k];
                end
                return POS_W'(lo_pos + longint'($urandom) % (hi_pos - lo_pos + 1));
            end
        endcase
    endfunction

    // Present one beat, hold it until accepted, then update the prediction
    task automatic send_beat(
        input logic beat_op,
        input logic [IDXIN_W-1:0] idx,
        input logic signed [POS_W-1:0] wpos,
        input logic signed [HGT_W-1:0] whgt,
        input logic signed [POS_W-1:0] qpos
    );
        @(negedge clk);
        while (!steady_flow && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= beat_op;
        entry_index <= idx;
        entry_position <= wpos;
        entry_height <= whgt;
        query_position <= qpos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (beat_op == OP_WRITE)
        begin
            shadow_pos[idx] = wpos;
            shadow_hgt[idx] = whgt;
            write_count++;
        end
        else
        begin
            expected_heights.push_back(interpolate_height(qpos));
            query_count++;
        end
    endtask

    task automatic send_write(
        input int unsigned idx,
        input longint wpos,
        input logic signed [HGT_W-1:0] whgt
    );
        send_beat(OP_WRITE, IDXIN_W'(idx), POS_W'(wpos), whgt, POS_W'($urandom));
    endtask

    task automatic send_query(input longint qpos);
        send_beat(OP_QUERY, IDXIN_W'($urandom), POS_W'($urandom), HGT_W'($urandom),
                  POS_W'(qpos));
    endtask

    // Drop valid, drain all heights, then let any trailing write finish
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_heights.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        shadow_count = value;
    endtask

    // Load all slots in ascending order with a random spacing scale
    task automatic load_sorted_table();
        longint step_max;
        longint next_pos;
        int unsigned i;
        step_max = longint'(1) << $urandom_range(25);
        next_pos = -(step_max * longint'($urandom_range(64)));
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (next_pos > POS_MAX)
                next_pos = POS_MAX;
            send_write(i, next_pos, pick_height());
            next_pos = next_pos + longint'($urandom) % (step_max + 1);
        end
    endtask

    // Mostly order-preserving writes, some arbitrary ones
    task automatic send_random_write();
        int unsigned idx;
        longint lo_pos;
        longint hi_pos;
        idx = $urandom_range(TABLE_DEPTH - 1);
        if ($urandom_range(3) == 0)
        begin
            send_write(idx, longint'(POS_W'($urandom)), pick_height());
        end
        else
        begin
            lo_pos = (idx == 0) ? POS_MIN : longint'(shadow_pos[idx-1]);
            hi_pos = (idx == TABLE_DEPTH - 1) ? POS_MAX : longint'(shadow_pos[idx+1]);
            if (hi_pos < lo_pos)
                hi_pos = lo_pos;
            send_write(idx, lo_pos + longint'($urandom) % (hi_pos - lo_pos + 1),
                       pick_height());
        end
    endtask

    task automatic run_random_phase(
        input logic [CFG_W-1:0] count_value,
        input bit refill,
        input bit steady
    );
        int unsigned i;
        write_point_count(count_value);
        steady_flow = steady;
        if (refill)
            load_sorted_table();
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if ($urandom_range(4) == 0)
                send_random_write();
            else
                send_query(longint'(pick_query_position()));
        end
        wait_idle();
        steady_flow = 1'b0;
    endtask

    // Count zero acts as one: every query clamps to the single entry
    task automatic test_single_point();
        write_point_count(CFG_W'(0));
        send_write(0, 0, 24'sh800000);
        send_query(POS_MIN);
        send_query(0);
        send_query(POS_MAX);
        wait_idle();
    endtask

    // Rails, exact hits, both slopes, duplicate positions, an unsorted pair
    task automatic test_small_table();
        write_point_count(CFG_W'(4));
        send_write(0, POS_MIN, 24'sh7FFFFF);
        send_write(1, -256, 24'sh800000);
        send_write(2, 256, HGT_W'(100));
        send_write(3, POS_MAX, 24'sh800000);
        send_query(-64'sd1073741824);
        send_query(-256);
        send_query(0);
        send_query(1000);
        send_query(POS_MAX);
        send_write(2, -256, 24'sh123456);
        send_query(-256);
        send_write(1, 1000, 24'sh000100);
        send_query(0);
        wait_idle();
    endtask

    task automatic test_full_table();
        run_random_phase(CFG_W'(64), 1'b1, 1'b0);
    endtask

    // Counts outside 1..64 clamp to the nearest legal size
    task automatic test_count_limits();
        run_random_phase(CFG_W'(127), 1'b0, 1'b0);
        run_random_phase(CFG_W'(0), 1'b1, 1'b0);
        run_random_phase(CFG_W'(65), 1'b0, 1'b0);
        run_random_phase(CFG_W'(1), 1'b0, 1'b0);
    endtask

    task automatic test_random_sizes();
        run_random_phase(CFG_W'(2), 1'b1, 1'b0);
        run_random_phase(CFG_W'(3), 1'b0, 1'b0);
        run_random_phase(CFG_W'($urandom_range(63, 4)), 1'b1, 1'b0);
    endtask

    // No gaps on the input and no stalls on the result side
    task automatic test_back_to_back();
        run_random_phase(CFG_W'(64), 1'b1, 1'b1);
    endtask

    // Randomly stall the result side
    always @(negedge clk)
        out_stall <= !steady_flow && ($urandom_range(99) < 9);

    // Compare each accepted height with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_heights.size() == 0)
            begin
                $error("height: expected none, actual %0d", height);
                fail_count++;
            end
            else
            begin
                head_height = expected_heights.pop_front();
                if (height !== head_height)
                begin
                    $error("height: expected %0d, actual %0d", head_height, height);
                    fail_count++;
                end
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d heights outstanding",
                     cycle_count, expected_heights.size());
            $display("piecewise_linear_height_lookup_unit regression: fail");
            $finish;
        end
    end

    initial
    begin
        int unsigned i;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        op = OP_WRITE;
        entry_index = '0;
        entry_position = '0;
        entry_height = '0;
        query_position = '0;
        shadow_count = CFG_W'(1);
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_pos[i] = '0;
            shadow_hgt[i] = '0;
        end
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        test_single_point();
        test_small_table();
        test_full_table();
        test_count_limits();
        test_random_sizes();
        test_back_to_back();

        $display("Covered %0d queries and %0d table writes, %0d heights checked,",
                 query_count, write_count, checked_count);
        $display("over table sizes 1 to 64 with count settings 0 and 127 included.");
        if (fail_count == 0)
            $display("piecewise_linear_height_lookup_unit regression: pass");
        else
            $display("piecewise_linear_height_lookup_unit regression: fail");
        $finish;
    end

endmodule
